FILE: hw/rtl/uer_pkg.sv
`default_nettype none

package uer_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } t_phase;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_ECHO = 2'd1,
        STATUS_TOO_LONG = 2'd2
    } t_status;

    localparam logic [7:0] CFG_TRIGGER_TICKS  = 8'd0;
    localparam logic [7:0] CFG_WAIT_LIMIT     = 8'd1;
    localparam logic [7:0] CFG_SAMPLE_DIVIDER = 8'd2;
    localparam logic [7:0] CFG_ECHO_LIMIT     = 8'd3;

    localparam logic [7:0]  RST_TRIGGER_TICKS  = 8'd20;
    localparam logic [15:0] RST_WAIT_LIMIT     = 16'd1000;
    localparam logic [7:0]  RST_SAMPLE_DIVIDER = 8'd9;
    localparam logic [15:0] RST_ECHO_LIMIT     = 16'd10000;

    localparam int DIST_BITS = 17;

    typedef struct packed {
        logic [DIST_BITS-1:0] distance;
        t_status              status;
        logic                 done_res;
        logic                 trigger_level;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic ranging controller for an echo sensor with trigger and echo pins.
// The slave stream carries one word per microsecond tick: a start request and
// the sampled echo level. Every accepted word yields exactly one master word
// holding the trigger pin level, a done flag, a status and a distance in mm.
// A start while idle raises the trigger for trigger_ticks ticks; the block
// then waits for echo, and while echo is high samples it every sample_divider
// ticks. Status 1 means echo never rose, status 2 means echo stayed too long.
// The result word is registered and is valid in the cycle after acceptance.
// Throughput is one word per cycle while the receiver is ready, set by the single
// output register, which still takes a new word in the cycle that the pending result is taken.
// When the receiver stalls, the result is held and the slave side is stalled.
// Configuration writes take effect at once and are accepted in every cycle;
// indexes beyond the last register are ignored. Synchronous reset restores
// the default register values, returns the sequencer to idle and clears the
// counters and the output valid flag.
`default_nettype none

module ultrasonic_echo_ranger
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // echo_level in bit 1, start_req in bit 0
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata,   // distance[16:0], status[1:0], done_res, trigger_level
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);

    logic [7:0]            r_trigger_ticks;
    logic [15:0]           r_wait_limit;
    logic [7:0]            r_sample_divider;
    logic [15:0]           r_echo_limit;

    t_phase                r_phase;
    logic [7:0]            r_trigger_count;
    logic [COUNT_BITS-1:0] r_wait_count;
    logic [7:0]            r_divider_count;
    logic [COUNT_BITS-1:0] r_width_count;

    t_phase                n_phase;
    logic [7:0]            n_trigger_count;
    logic [COUNT_BITS-1:0] n_wait_count;
    logic [7:0]            n_divider_count;
    logic [COUNT_BITS-1:0] n_width_count;
    t_result               n_result;

    logic                  r_out_valid;
    t_result               r_out;

    logic                  s_accept;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {3'b000, r_out};

    uer_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .i_start_req     (i_s_tdata[0]),
        .i_echo_level    (i_s_tdata[1]),
        .i_trigger_ticks (r_trigger_ticks),
        .i_wait_limit    (r_wait_limit),
        .i_sample_divider(r_sample_divider),
        .i_echo_limit    (r_echo_limit),
        .i_phase         (r_phase),
        .i_trigger_count (r_trigger_count),
        .i_wait_count    (r_wait_count),
        .i_divider_count (r_divider_count),
        .i_width_count   (r_width_count),
        .o_phase         (n_phase),
        .o_trigger_count (n_trigger_count),
        .o_wait_count    (n_wait_count),
        .o_divider_count (n_divider_count),
        .o_width_count   (n_width_count),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks  <= RST_TRIGGER_TICKS;
            r_wait_limit     <= RST_WAIT_LIMIT;
            r_sample_divider <= RST_SAMPLE_DIVIDER;
            r_echo_limit     <= RST_ECHO_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_TRIGGER_TICKS:  r_trigger_ticks  <= i_cfg_data[7:0];
                CFG_WAIT_LIMIT:     r_wait_limit     <= i_cfg_data;
                CFG_SAMPLE_DIVIDER: r_sample_divider <= i_cfg_data[7:0];
                CFG_ECHO_LIMIT:     r_echo_limit     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_trigger_count <= '0;
            r_wait_count    <= '0;
            r_divider_count <= '0;
            r_width_count   <= '0;
        end else if (s_accept) begin
            r_phase         <= n_phase;
            r_trigger_count <= n_trigger_count;
            r_wait_count    <= n_wait_count;
            r_divider_count <= n_divider_count;
            r_width_count   <= n_width_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_out <= n_result;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/uer_step.sv
`default_nettype none

module uer_step
    import uer_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_start_req,
    input  wire logic                  i_echo_level,
    input  wire logic [7:0]            i_trigger_ticks,
    input  wire logic [15:0]           i_wait_limit,
    input  wire logic [7:0]            i_sample_divider,
    input  wire logic [15:0]           i_echo_limit,
    input  wire t_phase                i_phase,
    input  wire logic [7:0]            i_trigger_count,
    input  wire logic [COUNT_BITS-1:0] i_wait_count,
    input  wire logic [7:0]            i_divider_count,
    input  wire logic [COUNT_BITS-1:0] i_width_count,
    output t_phase                     o_phase,
    output logic [7:0]                 o_trigger_count,
    output logic [COUNT_BITS-1:0]      o_wait_count,
    output logic [7:0]                 o_divider_count,
    output logic [COUNT_BITS-1:0]      o_width_count,
    output t_result                    o_result
);

    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

    logic                 trig_more;
    logic                 wait_expired;
    logic                 width_expired;
    logic                 echo_limit_zero;
    logic [7:0]           div_inc;
    logic                 sample_now;
    logic [DIST_BITS-1:0] half_width;
    logic [DIST_BITS-1:0] dist_mm;

    assign trig_more       = i_trigger_count < i_trigger_ticks;
    assign wait_expired    = (CW'(i_wait_count) >= CW'(i_wait_limit)) || (&i_wait_count);
    assign width_expired   = (CW'(i_width_count) >= CW'(i_echo_limit)) || (&i_width_count);
    assign echo_limit_zero = i_echo_limit == 16'd0;
    assign div_inc         = i_divider_count + 8'd1;
    assign sample_now      = div_inc >= i_sample_divider;
    assign half_width      = DIST_BITS'(i_width_count >> 1);
    assign dist_mm         = half_width + {half_width[DIST_BITS-2:0], 1'b0};

    always_comb begin
        o_phase = i_phase;
        case (i_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    o_phase = PH_TRIG;
                end
            end
            PH_TRIG: begin
                if (!trig_more) begin
                    o_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!i_echo_level) begin
                    if (wait_expired) begin
                        o_phase = PH_IDLE;
                    end
                end else if (echo_limit_zero) begin
                    o_phase = PH_IDLE;
                end else begin
                    o_phase = PH_MEAS;
                end
            end
            PH_MEAS: begin
                if (sample_now && (!i_echo_level || width_expired)) begin
                    o_phase = PH_IDLE;
                end
            end
            default: begin
                o_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_trigger_count        = i_trigger_count;
        o_wait_count           = i_wait_count;
        o_divider_count        = i_divider_count;
        o_width_count          = i_width_count;
        o_result.trigger_level = 1'b0;
        o_result.done_res      = 1'b0;
        o_result.status        = STATUS_OK;
        o_result.distance      = '0;
        case (i_phase)
            PH_IDLE: begin
                if (i_start_req) begin
                    o_trigger_count        = 8'd1;
                    o_result.trigger_level = 1'b1;
                end
            end
            PH_TRIG: begin
                if (trig_more) begin
                    o_trigger_count        = i_trigger_count + 8'd1;
                    o_result.trigger_level = 1'b1;
                end else begin
                    o_wait_count = '0;
                end
            end
            PH_WAIT: begin
                if (!i_echo_level) begin
                    if (wait_expired) begin
                        o_result.done_res = 1'b1;
                        o_result.status   = STATUS_NO_ECHO;
                    end else begin
                        o_wait_count = i_wait_count + ONE;
                    end
                end else begin
                    o_divider_count = 8'd0;
                    if (echo_limit_zero) begin
                        o_width_count     = '0;
                        o_result.done_res = 1'b1;
                        o_result.status   = STATUS_TOO_LONG;
                    end else begin
                        o_width_count = ONE;
                    end
                end
            end
            PH_MEAS: begin
                o_divider_count = div_inc;
                if (sample_now) begin
                    o_divider_count = 8'd0;
                    if (i_echo_level) begin
                        if (width_expired) begin
                            o_result.done_res = 1'b1;
                            o_result.status   = STATUS_TOO_LONG;
                        end else begin
                            o_width_count = i_width_count + ONE;
                        end
                    end else begin
                        o_result.done_res = 1'b1;
                        o_result.distance = dist_mm;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
